/* sv/sdtq_pkg.sv */
// Package for the sorted deadline timer queue.
// Holds the sizes, the input mode codes, the cell operation codes and the
// types shared by the cell and the top level. Depends on nothing.
package sdtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int OWNER_BITS  = 8;
  localparam int TIME_BITS   = 32;
  localparam int DELAY_BITS  = 16;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic                  vld;
    logic [TIME_BITS-1:0]  dl;
    logic [OWNER_BITS-1:0] own;
  } entry_t;

  typedef struct packed {
    logic [1:0]            op;
    logic                  match_en;
    logic [TIME_BITS-1:0]  new_dl;
    logic [OWNER_BITS-1:0] new_own;
  } cell_ctl_t;

endpackage

/* sv/sdtq_cell.sv */
// One slot of the sorted alarm chain: a deadline, an owner and a valid bit.
// Shifts right on insert and left on removal, using its neighbors' entries.
// Depends on sdtq_pkg.
module sdtq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sdtq_pkg::cell_ctl_t ctl,
  input  sdtq_pkg::entry_t   left_ent,
  input  sdtq_pkg::entry_t   right_ent,
  input  logic               keep_in,
  output logic               keep_out,
  input  logic               hit_in,
  output logic               hit_out,
  output sdtq_pkg::entry_t   ent
);
  import sdtq_pkg::*;

  logic                  vld_r, vld_nxt;
  logic [TIME_BITS-1:0]  dl_r, dl_nxt;
  logic [OWNER_BITS-1:0] own_r, own_nxt;
  logic                  keep;

  assign keep     = vld_r && (dl_r < ctl.new_dl);
  assign keep_out = keep;
  assign hit_out  = hit_in || (ctl.match_en && vld_r && (own_r == ctl.new_own));

  always_comb begin
    vld_nxt = vld_r;
    dl_nxt  = dl_r;
    own_nxt = own_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (!keep) begin
          if (keep_in) begin
            vld_nxt = 1'b1;
            dl_nxt  = ctl.new_dl;
            own_nxt = ctl.new_own;
          end else begin
            vld_nxt = left_ent.vld;
            dl_nxt  = left_ent.dl;
            own_nxt = left_ent.own;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_out) begin
          vld_nxt = right_ent.vld;
          dl_nxt  = right_ent.dl;
          own_nxt = right_ent.own;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r  <= dl_nxt;
    own_r <= own_nxt;
  end

  assign ent = '{vld: vld_r, dl: dl_r, own: own_r};

endmodule

/* sv/sorted_deadline_timer_queue.sv */
// Sorted deadline timer queue: a chain of cells kept in deadline order.
// Add inserts the alarm in deadline order; delete removes matching alarms one at a time and
// tick pops expired alarms one at a time, each ending with a closing last word.
// Results leave through one output register; a new word is taken once the
// previous one has closed. Synchronous reset empties the queue, zeroes time.
module sorted_deadline_timer_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [sdtq_pkg::OWNER_BITS-1:0] in_owner,
  input  logic [sdtq_pkg::DELAY_BITS-1:0] in_delay,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [sdtq_pkg::OWNER_BITS-1:0] out_owner_out,
  output logic                            out_accepted,
  output logic                            out_became_earliest,
  output logic                            out_removed_any,
  output logic                            out_last
);
  import sdtq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [OWNER_BITS-1:0] del_own_r, del_own_nxt;
  logic                  removed_r, removed_nxt;

  logic                  ov_r, ov_nxt;
  logic                  ok_r, ok_nxt;
  logic [OWNER_BITS-1:0] oo_r, oo_nxt;
  logic                  oa_r, oa_nxt;
  logic                  oe_r, oe_nxt;
  logic                  orm_r, orm_nxt;
  logic                  ol_r, ol_nxt;

  cell_ctl_t             ctl;
  logic                  hit_start;
  entry_t                ent [QUEUE_DEPTH];
  entry_t                left_e [QUEUE_DEPTH];
  entry_t                right_e [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]  keep_c;
  logic [QUEUE_DEPTH:0]  hit_c;

  logic                  out_free;
  logic                  accept;
  logic [TIME_BITS:0]    sum;
  logic [TIME_BITS-1:0]  new_dl;
  logic                  pop;

  assign keep_c[0] = 1'b1;
  assign hit_c[0]  = hit_start;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_e[gi] = '0;
      end else begin : g_mid
        assign left_e[gi] = ent[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_e[gi] = '0;
      end else begin : g_body
        assign right_e[gi] = ent[gi+1];
      end
      sdtq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .left_ent  (left_e[gi]),
        .right_ent (right_e[gi]),
        .keep_in   (keep_c[gi]),
        .keep_out  (keep_c[gi+1]),
        .hit_in    (hit_c[gi]),
        .hit_out   (hit_c[gi+1]),
        .ent       (ent[gi])
      );
    end
  endgenerate

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign sum    = {1'b0, now_r} + {{(TIME_BITS + 1 - DELAY_BITS){1'b0}}, in_delay};
  assign new_dl = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign pop    = ent[0].vld && (ent[0].dl <= now_r) && out_free;

  always_comb begin
    state_nxt   = state_r;
    now_nxt     = now_r;
    del_own_nxt = del_own_r;
    removed_nxt = removed_r;
    ov_nxt      = ov_r && out_stall;
    ok_nxt      = ok_r;
    oo_nxt      = oo_r;
    oa_nxt      = oa_r;
    oe_nxt      = oe_r;
    orm_nxt     = orm_r;
    ol_nxt      = ol_r;
    ctl         = '{op: OP_HOLD, match_en: 1'b0, new_dl: new_dl, new_own: in_owner};
    hit_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ov_nxt  = 1'b1;
          ok_nxt  = 1'b0;
          oo_nxt  = '0;
          oa_nxt  = 1'b0;
          oe_nxt  = 1'b0;
          orm_nxt = 1'b0;
          ol_nxt  = 1'b1;
          unique case (in_mode)
            MODE_ADD: begin
              if (!ent[QUEUE_DEPTH-1].vld) begin
                ctl.op = OP_INSERT;
                oa_nxt = 1'b1;
                oe_nxt = !ent[0].vld || (new_dl < ent[0].dl);
              end
            end
            MODE_DEL: begin
              ov_nxt      = 1'b0;
              del_own_nxt = in_owner;
              removed_nxt = 1'b0;
              state_nxt   = S_DEL;
            end
            MODE_TICK: begin
              ov_nxt = 1'b0;
              if (now_r != {TIME_BITS{1'b1}}) begin
                now_nxt = now_r + TIME_BITS'(1);
              end
              state_nxt = S_TICK;
            end
            default: begin
            end
          endcase
        end
      end
      S_DEL: begin
        ctl.op       = OP_REMOVE;
        ctl.match_en = 1'b1;
        ctl.new_own  = del_own_r;
        if (hit_c[QUEUE_DEPTH]) begin
          removed_nxt = 1'b1;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = 1'b0;
          oo_nxt    = '0;
          oa_nxt    = 1'b0;
          oe_nxt    = 1'b0;
          orm_nxt   = removed_r;
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (pop) begin
          ctl.op    = OP_REMOVE;
          hit_start = 1'b1;
          ov_nxt    = 1'b1;
          ok_nxt    = 1'b1;
          oo_nxt    = ent[0].own;
          oa_nxt    = 1'b0;
          oe_nxt    = 1'b0;
          orm_nxt   = 1'b0;
          ol_nxt    = 1'b0;
        end else if (out_free && !(ent[0].vld && (ent[0].dl <= now_r))) begin
          ov_nxt    = 1'b1;
          ok_nxt    = 1'b0;
          oo_nxt    = '0;
          oa_nxt    = 1'b0;
          oe_nxt    = 1'b0;
          orm_nxt   = 1'b0;
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    del_own_r <= del_own_nxt;
    removed_r <= removed_nxt;
    ok_r      <= ok_nxt;
    oo_r      <= oo_nxt;
    oa_r      <= oa_nxt;
    oe_r      <= oe_nxt;
    orm_r     <= orm_nxt;
    ol_r      <= ol_nxt;
  end

  assign out_valid           = ov_r;
  assign out_kind            = ok_r;
  assign out_owner_out       = oo_r;
  assign out_accepted        = oa_r;
  assign out_became_earliest = oe_r;
  assign out_removed_any     = orm_r;
  assign out_last            = ol_r;

endmodule

/* verif/tb_sorted_deadline_timer_queue.sv */
// Testbench for the sorted deadline timer queue: a scoreboard class predicts every
// result word and compares it with the block's output; a task drives the input handshake
// with gaps, a loop stalls the output. Depends on sdtq_pkg and sorted_deadline_timer_queue.

typedef struct packed {
  logic                            kind;
  logic [sdtq_pkg::OWNER_BITS-1:0] owner;
  logic                            accepted;
  logic                            became_earliest;
  logic                            removed_any;
  logic                            last;
} alarm_word_t;

class timer_scoreboard;
  logic [sdtq_pkg::TIME_BITS-1:0]  deadline_q [sdtq_pkg::QUEUE_DEPTH];
  logic [sdtq_pkg::OWNER_BITS-1:0] owner_q [sdtq_pkg::QUEUE_DEPTH];
  int                              used;
  logic [sdtq_pkg::TIME_BITS-1:0]  now_ticks;
  alarm_word_t                     awaited_q [$];
  int                              error_count;

  function new();
    used = 0;
    now_ticks = '0;
    error_count = 0;
    foreach (deadline_q[i]) begin
      deadline_q[i] = '0;
      owner_q[i] = '0;
    end
  endfunction

  function void drop_slot(int idx);
    for (int i = idx; i + 1 < used; i++) begin
      deadline_q[i] = deadline_q[i + 1];
      owner_q[i] = owner_q[i + 1];
    end
    used--;
  endfunction

  function void note_word(logic [1:0] mode, logic [sdtq_pkg::OWNER_BITS-1:0] own,
                          logic [sdtq_pkg::DELAY_BITS-1:0] delay);
    logic [sdtq_pkg::TIME_BITS:0]   sum;
    logic [sdtq_pkg::TIME_BITS-1:0] dl;
    alarm_word_t                    r;
    alarm_word_t                    fired;
    int                             pos;
    int                             i;
    r = '0;
    r.last = 1'b1;
    case (mode)
      sdtq_pkg::MODE_ADD: begin
        sum = {1'b0, now_ticks}
              + {{(sdtq_pkg::TIME_BITS + 1 - sdtq_pkg::DELAY_BITS){1'b0}}, delay};
        dl = sum[sdtq_pkg::TIME_BITS] ? '1 : sum[sdtq_pkg::TIME_BITS-1:0];
        if (used < sdtq_pkg::QUEUE_DEPTH) begin
          r.accepted = 1'b1;
          r.became_earliest = (used == 0) || (dl < deadline_q[0]);
          pos = 0;
          while (pos < used && deadline_q[pos] < dl) pos++;
          for (i = used; i > pos; i--) begin
            deadline_q[i] = deadline_q[i - 1];
            owner_q[i] = owner_q[i - 1];
          end
          deadline_q[pos] = dl;
          owner_q[pos] = own;
          used++;
        end
      end
      sdtq_pkg::MODE_DEL: begin
        i = 0;
        while (i < used) begin
          if (owner_q[i] == own) begin
            drop_slot(i);
            r.removed_any = 1'b1;
          end else begin
            i++;
          end
        end
      end
      sdtq_pkg::MODE_TICK: begin
        if (now_ticks != '1) now_ticks++;
        while (used > 0 && deadline_q[0] <= now_ticks) begin
          fired = '0;
          fired.kind = 1'b1;
          fired.owner = owner_q[0];
          awaited_q.push_back(fired);
          drop_slot(0);
        end
      end
      default: begin
      end
    endcase
    awaited_q.push_back(r);
  endfunction

  function void check_word(alarm_word_t got);
    alarm_word_t exp;
    if (awaited_q.size() == 0) begin
      $display("%0t: unexpected result word: kind=%0d owner=%0h acc=%0d early=%0d",
               $time, got.kind, got.owner, got.accepted, got.became_earliest);
      $display("%0t:   rem=%0d last=%0d", $time, got.removed_any, got.last);
      error_count++;
    end else begin
      exp = awaited_q.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected kind=%0d owner=%0h acc=%0d early=%0d rem=%0d last=%0d",
                 $time, exp.kind, exp.owner, exp.accepted, exp.became_earliest,
                 exp.removed_any, exp.last);
        $display("%0t:          actual   kind=%0d owner=%0h acc=%0d early=%0d rem=%0d last=%0d",
                 $time, got.kind, got.owner, got.accepted, got.became_earliest,
                 got.removed_any, got.last);
        error_count++;
      end
    end
  endfunction
endclass

module tb_sorted_deadline_timer_queue;
  import sdtq_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_mode;
  logic [OWNER_BITS-1:0] in_owner;
  logic [DELAY_BITS-1:0] in_delay;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_kind;
  logic [OWNER_BITS-1:0] out_owner_out;
  logic                  out_accepted;
  logic                  out_became_earliest;
  logic                  out_removed_any;
  logic                  out_last;

  bit calm;
  bit pressure_req;
  int hold_left;
  timer_scoreboard sb = new();

  sorted_deadline_timer_queue dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_owner            (in_owner),
    .in_delay            (in_delay),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_owner_out       (out_owner_out),
    .out_accepted        (out_accepted),
    .out_became_earliest (out_became_earliest),
    .out_removed_any     (out_removed_any),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("tb_sorted_deadline_timer_queue: errors");
    $finish;
  end

  task automatic send_word(input logic [1:0] mode, input logic [OWNER_BITS-1:0] own,
                           input logic [DELAY_BITS-1:0] delay);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_owner <= own;
    in_delay <= delay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(mode, own, delay);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    alarm_word_t got;
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind = out_kind;
        got.owner = out_owner_out;
        got.accepted = out_accepted;
        got.became_earliest = out_became_earliest;
        got.removed_any = out_removed_any;
        got.last = out_last;
        sb.check_word(got);
      end
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 11);
      end
    end
  end

  initial begin
    logic [1:0]            mode;
    logic [OWNER_BITS-1:0] own;
    logic [DELAY_BITS-1:0] delay;
    int                    pick;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_mode  <= MODE_ADD;
    in_owner <= '0;
    in_delay <= '0;
    calm = 1'b0;
    pressure_req = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_word(MODE_TICK, 8'h00, 16'h0000);
    send_word(MODE_ADD, 8'h00, 16'h0000);
    send_word(MODE_ADD, 8'hFF, 16'h0000);
    send_word(MODE_ADD, 8'h5A, 16'hFFFF);
    send_word(MODE_ADD, 8'hA5, 16'h0003);
    send_word(MODE_TICK, 8'hFF, 16'hFFFF);
    send_word(MODE_DEL, 8'h5A, 16'h0000);
    send_word(MODE_DEL, 8'h77, 16'h0000);
    send_word(MODE_SPARE, 8'hFF, 16'hFFFF);
    send_word(MODE_ADD, 8'hA5, 16'h0000);
    for (int i = 0; i < 15; i++)
      send_word(MODE_ADD, (i % 2) ? 8'hC3 : 8'h3C, 16'(10 + 2 * i));
    send_word(MODE_DEL, 8'h3C, 16'h0000);
    send_word(MODE_TICK, 8'h00, 16'h0000);

    for (int n = 0; n < 103; n++) begin
      if (n == 40) pressure_req = 1'b1;
      calm = (n >= 60 && n < 90);
      pick = $urandom_range(0, 99);
      if (pick < 45) mode = MODE_ADD;
      else if (pick < 80) mode = MODE_TICK;
      else if (pick < 95) mode = MODE_DEL;
      else mode = MODE_SPARE;
      if ($urandom_range(0, 99) < 80) own = 8'(8'h29 * $urandom_range(0, 6));
      else own = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 70) delay = 16'($urandom_range(0, 24));
      else if (pick < 90) delay = 16'($urandom_range(0, 300));
      else delay = 16'($urandom_range(0, 65535));
      send_word(mode, own, delay);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("tb_sorted_deadline_timer_queue: clean");
    end else begin
      $display("tb_sorted_deadline_timer_queue: errors");
    end
    $finish;
  end
endmodule
